/* design/oteq_pkg.sv */
// Types, codes and compare helpers for the ordered timer event queue.
package oteq_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned PeriodW = 31;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned IdW     = 16;
  localparam int unsigned MaxFire = 16;
  localparam logic [IdW-1:0] IdLimit = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_PRIO     = 2'd2,
    OP_ROUND    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_FND = 2'd2,
    ST_NO_DUE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_CLR,
    S_PROT,
    S_RCNT,
    S_RFIRE,
    S_RREQ
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0]       due;
    logic [PeriodW-1:0]     per;
    logic                   rep;
    logic signed [PrioW-1:0] prio;
    logic [IdW-1:0]         id;
  } entry_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [PeriodW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW+1-PeriodW){1'b0}}, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  function automatic logic ahead(input entry_t a, input entry_t b);
    if (a.due != b.due) return a.due < b.due;
    if (a.prio != b.prio) return a.prio < b.prio;
    return a.id < b.id;
  endfunction

endpackage

/* design/ordered_timer_event_queue_core.sv */
// Ordered timer event queue: sorted entry table, one comparator under a sequencer.
// One command at a time; earlier result words come while busy is high, the last may come after it drops.
// Results are one-cycle strobes and cannot be stalled.
// Reset clears occupancy, id counter and logical time; entry storage is not reset.
module ordered_timer_event_queue_core import oteq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode_i,
  input  logic [TimeW-1:0]         now_time_i,
  input  logic [PeriodW-1:0]       delay_i,
  input  logic                     periodic_i,
  input  logic signed [PrioW-1:0]  priority_req_i,
  input  logic [IdW-1:0]           entry_id_i,
  input  logic signed [PrioW-1:0]  old_priority_i,
  input  logic signed [PrioW-1:0]  new_priority_i,
  output logic                     result_valid_o,
  output logic [1:0]               status_o,
  output logic [IdW-1:0]           result_id_o,
  output logic [TimeW-1:0]         fire_time_o,
  output logic                     last_o
);

  localparam int unsigned D  = QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(D);
  localparam int unsigned IW = $clog2(D+1);
  localparam logic [IW-1:0] DepthC = IW'(D);
  localparam logic [IW-1:0] OneC   = IW'(1);

  state_e state_q, state_d;
  entry_t arr_q [D];
  entry_t rot [D];
  entry_t cand_q, rd;
  logic [IW-1:0] occ_q, idx_q, pend_q, pf_q, fc_q, k_q;
  logic [IdW-1:0] nid_q, id_q;
  logic [TimeW-1:0] lt_q, now_q;
  logic signed [PrioW-1:0] oldp_q, newp_q;
  logic round_q, req_q;
  logic rv_q, last_q;
  logic [1:0] st_q;
  logic [IdW-1:0] rid_q;
  logic [TimeW-1:0] ft_q;
  logic [IW-1:0] pend_addr;
  logic [AW-1:0] rd_addr;
  logic full_c, nodue_c, ins_go, clr_hit, cnt_go;
  op_e op_c;

  assign op_c      = op_e'(opcode_i);
  assign pend_addr = DepthC - pend_q + pf_q;
  assign rd_addr   = (state_q == S_RREQ) ? pend_addr[AW-1:0] : idx_q[AW-1:0];
  assign rd        = arr_q[rd_addr];
  assign full_c    = (occ_q >= DepthC) || (nid_q >= IdLimit);
  assign nodue_c   = (occ_q == '0) || (arr_q[0].due > now_time_i);
  assign ins_go    = (idx_q < occ_q) && !ahead(cand_q, rd);
  assign clr_hit   = (idx_q < occ_q) && (rd.id == id_q);
  assign cnt_go    = (idx_q < occ_q) && (32'(idx_q) < MaxFire) && (rd.due <= lt_q);

  always_comb begin
    for (int j = 0; j < D - 1; j++) begin
      rot[j] = arr_q[j+1];
    end
    rot[D-1] = arr_q[0];
    if (state_q == S_PROT && arr_q[0].prio == oldp_q) begin
      rot[D-1].prio = newp_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (op_c)
            OP_SCHEDULE: state_d = full_c ? S_IDLE : S_INS;
            OP_CLEAR:    state_d = S_CLR;
            OP_PRIO:     state_d = (occ_q == '0) ? S_IDLE : S_PROT;
            OP_ROUND:    state_d = nodue_c ? S_IDLE : S_RCNT;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_INS:   if (!ins_go) state_d = req_q ? S_RREQ : S_IDLE;
      S_CLR:   if (clr_hit || idx_q >= occ_q) state_d = S_IDLE;
      S_PROT:  if (idx_q == pend_q - OneC) state_d = S_RREQ;
      S_RCNT:  if (!cnt_go) state_d = S_RFIRE;
      S_RFIRE: if (fc_q == k_q - OneC) state_d = S_RREQ;
      S_RREQ: begin
        if (pf_q == pend_q) state_d = S_IDLE;
        else if (!(round_q && !rd.rep)) state_d = S_INS;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state_q != S_IDLE);
    result_valid_o = rv_q;
    status_o       = st_q;
    result_id_o    = rid_q;
    fire_time_o    = ft_q;
    last_o         = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      nid_q   <= '0;
      lt_q    <= '0;
      rv_q    <= 1'b0;
      req_q   <= 1'b0;
      round_q <= 1'b0;
      idx_q   <= '0;
      pend_q  <= '0;
      pf_q    <= '0;
      fc_q    <= '0;
      k_q     <= '0;
      st_q    <= ST_OK;
      rid_q   <= '0;
      ft_q    <= '0;
      last_q  <= 1'b0;
      cand_q  <= '0;
      now_q   <= '0;
      id_q    <= '0;
      oldp_q  <= '0;
      newp_q  <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= 1'b0;
      st_q    <= ST_OK;
      rid_q   <= '0;
      ft_q    <= '0;
      last_q  <= 1'b1;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            now_q  <= now_time_i;
            id_q   <= entry_id_i;
            oldp_q <= old_priority_i;
            newp_q <= new_priority_i;
            idx_q  <= '0;
            pf_q   <= '0;
            fc_q   <= '0;
            req_q  <= 1'b0;
            unique case (op_c)
              OP_SCHEDULE: begin
                rv_q <= 1'b1;
                if (full_c) begin
                  st_q <= ST_FULL;
                end else begin
                  cand_q.due  <= sat_add(lt_q, delay_i);
                  cand_q.per  <= delay_i;
                  cand_q.rep  <= periodic_i;
                  cand_q.prio <= priority_req_i;
                  cand_q.id   <= nid_q;
                  rid_q       <= nid_q;
                  ft_q        <= sat_add(lt_q, delay_i);
                  nid_q       <= nid_q + 1'b1;
                end
              end
              OP_CLEAR: ;
              OP_PRIO: begin
                round_q <= 1'b0;
                pend_q  <= occ_q;
                if (occ_q == '0) rv_q <= 1'b1;
              end
              OP_ROUND: begin
                round_q <= 1'b1;
                if (nodue_c) begin
                  rv_q <= 1'b1;
                  st_q <= ST_NO_DUE;
                  if (occ_q == '0) begin
                    nid_q <= '0;
                    lt_q  <= now_time_i;
                  end
                end else begin
                  lt_q <= arr_q[0].due;
                end
              end
              default: ;
            endcase
          end
        end
        S_INS: begin
          if (ins_go) begin
            idx_q <= idx_q + OneC;
          end else begin
            for (int j = 0; j < D; j++) begin
              if (IW'(j) == idx_q) arr_q[j] <= cand_q;
              else if (IW'(j) > idx_q && IW'(j) <= occ_q && j > 0) arr_q[j] <= arr_q[j-1];
            end
            occ_q <= occ_q + OneC;
          end
        end
        S_CLR: begin
          if (clr_hit || idx_q >= occ_q) begin
            rv_q  <= 1'b1;
            rid_q <= id_q;
            st_q  <= clr_hit ? ST_OK : ST_NOT_FND;
            if (clr_hit) begin
              for (int j = 0; j < D - 1; j++) begin
                if (IW'(j) >= idx_q) arr_q[j] <= arr_q[j+1];
              end
              occ_q <= occ_q - OneC;
            end
            if (occ_q == '0 || (clr_hit && occ_q == OneC)) begin
              nid_q <= '0;
              lt_q  <= now_q;
            end
          end else begin
            idx_q <= idx_q + OneC;
          end
        end
        S_PROT: begin
          arr_q <= rot;
          idx_q <= idx_q + OneC;
          if (idx_q == pend_q - OneC) begin
            occ_q <= '0;
            req_q <= 1'b1;
          end
        end
        S_RCNT: begin
          if (cnt_go) idx_q <= idx_q + OneC;
          else k_q <= idx_q;
        end
        S_RFIRE: begin
          rv_q   <= 1'b1;
          rid_q  <= arr_q[0].id;
          ft_q   <= arr_q[0].due;
          last_q <= (fc_q == k_q - OneC);
          arr_q  <= rot;
          occ_q  <= occ_q - OneC;
          fc_q   <= fc_q + OneC;
          if (fc_q == k_q - OneC) begin
            pend_q <= k_q;
            req_q  <= 1'b1;
          end
        end
        S_RREQ: begin
          if (pf_q == pend_q) begin
            req_q <= 1'b0;
            if (round_q) begin
              if (occ_q == '0) begin
                nid_q <= '0;
                lt_q  <= now_q;
              end
            end else begin
              rv_q <= 1'b1;
            end
          end else begin
            pf_q <= pf_q + OneC;
            if (!(round_q && !rd.rep)) begin
              cand_q <= rd;
              if (round_q) cand_q.due <= sat_add(rd.due, rd.per);
              idx_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DepthC) else $error("occupancy above depth");
  a_fire_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RFIRE |=> result_valid_o && status_o == ST_OK)
    else $error("fired word missing");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_FULL |-> result_id_o == '0 && fire_time_o == '0)
    else $error("full word carries payload");
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy) else $error("block idle before last word");
`endif

endmodule

/* tb/sv/tb.sv */
// Testbench for the ordered timer event queue: mirror of the queue, scoreboard and drivers.
`timescale 1ns / 1ps

module tb;
  import oteq_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int unsigned StallLimit = 20000;

  typedef struct {
    status_e          status;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] fire;
    logic             last;
  } outcome_t;

  class timer_queue_mirror;
    logic [TimeW-1:0]        due[Depth];
    logic [PeriodW-1:0]      per[Depth];
    logic                    rep[Depth];
    logic signed [PrioW-1:0] prio[Depth];
    logic [IdW-1:0]          ident[Depth];
    int unsigned             order[Depth];
    int unsigned             occ;
    logic [16:0]             next_id;
    logic [TimeW-1:0]        ltime;
    outcome_t                awaited[$];
    int unsigned             errors;

    function void wipe();
      for (int i = 0; i < Depth; i++) order[i] = i;
      occ = 0;
      next_id = 0;
      ltime = 0;
      errors = 0;
    endfunction

    function logic [TimeW-1:0] sat_sum(logic [TimeW-1:0] a, logic [PeriodW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + b;
      return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
    endfunction

    function bit earlier(int unsigned a, int unsigned b);
      if (due[a] != due[b]) return due[a] < due[b];
      if (prio[a] != prio[b]) return prio[a] < prio[b];
      return ident[a] < ident[b];
    endfunction

    function void place(int unsigned s);
      int unsigned pos;
      int unsigned t;
      pos = 0;
      for (int j = occ; j < Depth; j++) begin
        if (order[j] == s) begin
          t = order[occ];
          order[occ] = order[j];
          order[j] = t;
          break;
        end
      end
      while (pos < occ && !earlier(s, order[pos])) pos++;
      for (int j = occ; j > pos; j--) order[j] = order[j-1];
      order[pos] = s;
      occ++;
    endfunction

    function void take(int unsigned p);
      int unsigned s;
      s = order[p];
      for (int j = p; j + 1 < occ; j++) order[j] = order[j+1];
      order[occ-1] = s;
      occ--;
    endfunction

    function void await_result(status_e st, logic [IdW-1:0] id, logic [TimeW-1:0] ft,
                               logic lst);
      outcome_t o;
      o.status = st;
      o.id = id;
      o.fire = ft;
      o.last = lst;
      awaited = {awaited, o};
    endfunction

    function void note(op_e op, logic [TimeW-1:0] now, logic [PeriodW-1:0] dly, logic pd,
                       logic signed [PrioW-1:0] preq, logic [IdW-1:0] eid,
                       logic signed [PrioW-1:0] oldp, logic signed [PrioW-1:0] newp);
      int unsigned s;
      int unsigned k;
      int unsigned v;
      int          j;
      int unsigned fired[MaxFire];
      logic [TimeW-1:0] t;
      status_e st;
      case (op)
        OP_SCHEDULE: begin
          if (occ >= Depth || next_id >= IdLimit) begin
            await_result(ST_FULL, 0, 0, 1'b1);
          end else begin
            s = order[occ];
            due[s] = sat_sum(ltime, dly);
            per[s] = dly;
            rep[s] = pd;
            prio[s] = preq;
            ident[s] = next_id[IdW-1:0];
            next_id++;
            place(s);
            await_result(ST_OK, ident[s], due[s], 1'b1);
          end
        end
        OP_CLEAR: begin
          st = ST_NOT_FND;
          for (int i = 0; i < occ; i++) begin
            if (ident[order[i]] == eid) begin
              take(i);
              st = ST_OK;
              break;
            end
          end
          if (occ == 0) restart(now);
          await_result(st, eid, 0, 1'b1);
        end
        OP_PRIO: begin
          for (int i = 0; i < occ; i++)
            if (prio[order[i]] == oldp) prio[order[i]] = newp;
          for (int i = 1; i < occ; i++) begin
            v = order[i];
            j = i;
            while (j > 0 && earlier(v, order[j-1])) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = v;
          end
          await_result(ST_OK, 0, 0, 1'b1);
        end
        default: begin
          if (occ == 0 || due[order[0]] > now) begin
            if (occ == 0) restart(now);
            await_result(ST_NO_DUE, 0, 0, 1'b1);
          end else begin
            t = due[order[0]];
            ltime = t;
            k = 0;
            while (k < occ && k < MaxFire && due[order[k]] <= t) begin
              fired[k] = order[k];
              k++;
            end
            for (int i = 0; i < k; i++)
              await_result(ST_OK, ident[fired[i]], due[fired[i]], i + 1 == k);
            for (int i = 0; i < k; i++) take(0);
            for (int i = 0; i < k; i++) begin
              if (rep[fired[i]]) begin
                due[fired[i]] = sat_sum(due[fired[i]], per[fired[i]]);
                place(fired[i]);
              end
            end
            if (occ == 0) restart(now);
          end
        end
      endcase
    endfunction

    function void restart(logic [TimeW-1:0] now);
      occ = 0;
      next_id = 0;
      ltime = now;
    endfunction

    function void check(logic [1:0] st, logic [IdW-1:0] id, logic [TimeW-1:0] ft, logic lst);
      outcome_t o;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d id %0d fire_time %0d", st, id, ft);
        errors++;
        return;
      end
      o = awaited.pop_front();
      if (st != o.status) begin
        $error("status: expected %0d, got %0d", o.status, st);
        errors++;
      end
      if (id != o.id) begin
        $error("result_id: expected %0d, got %0d", o.id, id);
        errors++;
      end
      if (ft != o.fire) begin
        $error("fire_time: expected %0d, got %0d", o.fire, ft);
        errors++;
      end
      if (lst != o.last) begin
        $error("last: expected %0d, got %0d", o.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              opcode_i;
  logic [TimeW-1:0]        now_time_i;
  logic [PeriodW-1:0]      delay_i;
  logic                    periodic_i;
  logic signed [PrioW-1:0] priority_req_i;
  logic [IdW-1:0]          entry_id_i;
  logic signed [PrioW-1:0] old_priority_i;
  logic signed [PrioW-1:0] new_priority_i;
  logic                    result_valid_o;
  logic [1:0]              status_o;
  logic [IdW-1:0]          result_id_o;
  logic [TimeW-1:0]        fire_time_o;
  logic                    last_o;

  timer_queue_mirror mirror;
  int unsigned       idle_pct;
  int unsigned       quiet_cycles = 0;

  ordered_timer_event_queue_core #(.QUEUE_DEPTH(Depth)) i_dut (.*);

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) mirror.check(status_o, result_id_o, fire_time_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(op_e op, logic [TimeW-1:0] now, logic [PeriodW-1:0] dly, logic pd,
                       logic signed [PrioW-1:0] preq, logic [IdW-1:0] eid,
                       logic signed [PrioW-1:0] oldp, logic signed [PrioW-1:0] newp);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    opcode_i       <= op;
    now_time_i     <= now;
    delay_i        <= dly;
    periodic_i     <= pd;
    priority_req_i <= preq;
    entry_id_i     <= eid;
    old_priority_i <= oldp;
    new_priority_i <= newp;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    mirror.note(op, now, dly, pd, preq, eid, oldp, newp);
  endtask

  task automatic schedule(logic [PeriodW-1:0] dly, logic pd, logic signed [PrioW-1:0] preq);
    issue(OP_SCHEDULE, TimeW'({$urandom, $urandom}), dly, pd, preq, IdW'($urandom),
          PrioW'($urandom), PrioW'($urandom));
  endtask

  task automatic clear_id(logic [IdW-1:0] eid, logic [TimeW-1:0] now);
    issue(OP_CLEAR, now, PeriodW'($urandom), 1'($urandom), PrioW'($urandom), eid,
          PrioW'($urandom), PrioW'($urandom));
  endtask

  task automatic run_round(logic [TimeW-1:0] now);
    issue(OP_ROUND, now, PeriodW'($urandom), 1'($urandom), PrioW'($urandom), IdW'($urandom),
          PrioW'($urandom), PrioW'($urandom));
  endtask

  task automatic drain(logic [TimeW-1:0] now);
    while (mirror.occ > 0) clear_id(mirror.ident[mirror.order[0]], now);
  endtask

  function automatic logic signed [PrioW-1:0] pick_prio();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return -16'sd1;
      3: return PrioW'($urandom);
      default: return PrioW'($urandom_range(3));
    endcase
  endfunction

  task automatic random_word();
    logic [TimeW-1:0]   now;
    logic [PeriodW-1:0] dly;
    logic [IdW-1:0]     eid;
    int unsigned        pick;
    now = ($urandom_range(19) == 0) ? TimeW'({$urandom, $urandom}) :
          TimeW'(mirror.ltime + $urandom_range(150));
    dly = ($urandom_range(9) == 0) ? PeriodW'($urandom) : PeriodW'($urandom_range(120));
    if (mirror.occ > 0 && $urandom_range(3) != 0)
      eid = mirror.ident[mirror.order[$urandom_range(mirror.occ - 1)]];
    else
      eid = ($urandom_range(1) == 0) ? IdW'($urandom) : IdW'($urandom_range(20));
    pick = $urandom_range(99);
    if (pick < 40)
      issue(OP_SCHEDULE, now, dly, 1'($urandom), pick_prio(), eid, pick_prio(), pick_prio());
    else if (pick < 55)
      issue(OP_CLEAR, now, dly, 1'($urandom), pick_prio(), eid, pick_prio(), pick_prio());
    else if (pick < 65)
      issue(OP_PRIO, now, dly, 1'($urandom), pick_prio(), eid, pick_prio(), pick_prio());
    else
      issue(OP_ROUND, now, dly, 1'($urandom), pick_prio(), eid, pick_prio(), pick_prio());
  endtask

  initial begin
    int unsigned phase_pct[4] = '{0, 75, 0, 27};
    mirror = new();
    mirror.wipe();
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = OP_SCHEDULE;
    now_time_i = '0;
    delay_i = '0;
    periodic_i = 1'b0;
    priority_req_i = '0;
    entry_id_i = '0;
    old_priority_i = '0;
    new_priority_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_round(48'd5);
    clear_id(16'd7, 48'd0);
    schedule(31'd0, 1'b1, 16'sd0);
    schedule({PeriodW{1'b1}}, 1'b0, 16'sh8000);
    schedule(31'd10, 1'b1, 16'sh7FFF);
    schedule(31'd10, 1'b0, 16'sh8000);
    issue(OP_PRIO, 48'd0, 31'd0, 1'b0, 16'sd0, 16'd0, 16'sh7FFF, -16'sd1);
    run_round(48'd0);
    run_round(48'd20);
    clear_id(16'd0, 48'd20);
    run_round(48'd20);
    clear_id(16'hFFFF, 48'd20);
    while (mirror.occ < Depth) schedule(PeriodW'($urandom_range(50)), 1'($urandom), pick_prio());
    schedule(31'd1, 1'b0, 16'sd0);
    drain({TimeW{1'b1}});
    schedule({PeriodW{1'b1}}, 1'b1, 16'sd0);
    schedule(31'd0, 1'b1, 16'sd0);
    run_round({TimeW{1'b1}});
    run_round({TimeW{1'b1}});
    drain(48'd0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      repeat (60) random_word();
    end

    idle_pct = 0;
    drain(48'd0);
    schedule(31'd1000, 1'b0, 16'sd0);
    schedule(31'd5, 1'b0, 16'sd0);
    drain(48'd3);
    schedule(31'd5, 1'b1, 16'sd0);
    run_round(48'd100);

    start <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
